// ===== hw/rtl/tbsc_pkg.sv =====
// Shared types for the byte-wide SPN cipher unit.
// Holds the configuration bundle and register map; no dependencies.
`default_nettype none

package tbsc_pkg;

  // Register map: index is paddr[3:2]
  typedef enum logic [1:0] {
    REG_KEY  = 2'd0,
    REG_IV   = 2'd1,
    REG_MODE = 2'd2,
    REG_DIR  = 2'd3
  } reg_idx_e;

  localparam int unsigned AddrWidth = 4;
  localparam int unsigned DataWidth = 32;

  // Configuration bundle from the register block to the datapath
  typedef struct packed {
    logic [31:0] cipher_key;
    logic [7:0]  init_vector;
    logic        chain_mode;   // 0 = ECB, 1 = CBC
    logic        direction;    // 0 = encrypt, 1 = decrypt
  } cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tbsc_regs.sv =====
// APB-style configuration registers for the cipher unit.
// Depends on tbsc_pkg for the register map and configuration struct.
`default_nettype none

module tbsc_regs (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [tbsc_pkg::AddrWidth-1:0]    paddr,
  input  wire logic [tbsc_pkg::DataWidth-1:0]    pwdata,
  output logic      [tbsc_pkg::DataWidth-1:0]    prdata,
  output logic                                   pready,
  output tbsc_pkg::cfg_t                         cfg_o
);
  import tbsc_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  // Write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_KEY:  cfg_d.cipher_key  = pwdata;
        REG_IV:   cfg_d.init_vector = pwdata[7:0];
        REG_MODE: cfg_d.chain_mode  = pwdata[0];
        REG_DIR:  cfg_d.direction   = pwdata[0];
        default:  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read-back mux
  always_comb begin
    case (idx)
      REG_KEY:  prdata = cfg_q.cipher_key;
      REG_IV:   prdata = {24'd0, cfg_q.init_vector};
      REG_MODE: prdata = {31'd0, cfg_q.chain_mode};
      REG_DIR:  prdata = {31'd0, cfg_q.direction};
      default:  prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== hw/rtl/tbsc_core.sv =====
// Combinational round logic: three-round byte SPN, encrypt or decrypt,
// with CBC chaining XOR. Depends on tbsc_pkg for the configuration struct.
`default_nettype none

module tbsc_core (
  input  wire logic [7:0]     data_i,
  input  wire logic           start_i,
  input  wire logic [7:0]     chain_i,
  input  tbsc_pkg::cfg_t      cfg_i,
  output logic      [7:0]     result_o,
  output logic      [7:0]     chain_next_o
);
  import tbsc_pkg::*;

  localparam logic [3:0] InvNib [16] = '{
    4'd15, 4'd6, 4'd13, 4'd4, 4'd11, 4'd2, 4'd9, 4'd0,
    4'd7, 4'd14, 4'd5, 4'd12, 4'd3, 4'd10, 4'd1, 4'd8
  };

  // Forward nibble: ((x + 1) * 7) mod 16
  function automatic logic [3:0] fwd_nib(input logic [3:0] x);
    logic [7:0] t;
    t = ({4'd0, x} + 8'd1) * 8'd7;
    return t[3:0];
  endfunction

  function automatic logic [7:0] sub_fwd(input logic [7:0] b);
    return {fwd_nib(b[7:4]), fwd_nib(b[3:0])};
  endfunction

  function automatic logic [7:0] sub_inv(input logic [7:0] b);
    return {InvNib[b[7:4]], InvNib[b[3:0]]};
  endfunction

  function automatic logic [7:0] rotl2(input logic [7:0] b);
    return {b[5:0], b[7:6]};
  endfunction

  function automatic logic [7:0] rotr2(input logic [7:0] b);
    return {b[1:0], b[7:2]};
  endfunction

  logic [7:0] k0, k1, k2, k3;
  logic [7:0] chain_sel;
  logic [7:0] enc_in, enc_r1, enc_r2, enc_out;
  logic [7:0] dec_r1, dec_r2, dec_r3, dec_out;

  assign k0 = cfg_i.cipher_key[7:0];
  assign k1 = cfg_i.cipher_key[15:8];
  assign k2 = cfg_i.cipher_key[23:16];
  assign k3 = cfg_i.cipher_key[31:24];

  // Chaining value: IV on a message start, else last ciphertext; zero in ECB
  assign chain_sel = !cfg_i.chain_mode ? 8'd0 :
                     (start_i ? cfg_i.init_vector : chain_i);

  // Encrypt path, key bytes high to low
  assign enc_in  = data_i ^ chain_sel ^ k3;
  assign enc_r1  = rotl2(sub_fwd(enc_in)) ^ k2;
  assign enc_r2  = rotl2(sub_fwd(enc_r1)) ^ k1;
  assign enc_out = sub_fwd(enc_r2) ^ k0;

  // Decrypt path, exact inverse
  assign dec_r1  = sub_inv(data_i ^ k0);
  assign dec_r2  = sub_inv(rotr2(dec_r1 ^ k1));
  assign dec_r3  = sub_inv(rotr2(dec_r2 ^ k2));
  assign dec_out = dec_r3 ^ k3 ^ chain_sel;

  // Chain register always follows the ciphertext side
  assign result_o     = cfg_i.direction ? dec_out : enc_out;
  assign chain_next_o = cfg_i.direction ? data_i  : enc_out;

endmodule

`default_nettype wire

// ===== hw/rtl/toy_byte_spn_cipher_ecb_cbc_unit.sv =====
// Top level of the byte-wide SPN cipher unit (ECB / CBC).
// Uses tbsc_pkg, tbsc_regs and tbsc_core.
//
// Usage:
//   Input stream s_axis: one byte per beat in tdata, tuser = message start.
//   Output stream m_axis: one result byte per accepted input beat, in order.
//   APB port: key @0x0, IV @0x4, chain mode @0x8, direction @0xC. Write
//   these only while the unit is idle.
// Path: an accepted beat is held in the input register, passes the cipher
//   rounds and lands in the output register, from which it is offered on
//   m_axis; while the output register is stalled it waits in the input one.
// Throughput: one byte per clock while m_axis_tready is high. The CBC chain
//   register moves in the same cycle as the output register, keeping that rate.
// Reset: clears the config registers (key, IV, modes) and the chain byte to
//   zero; both pipeline stages come out empty (their data is not reset).
// Stall: when m_axis_tready is low the output register holds its beat; the
//   input register still takes one more beat, after which s_axis_tready
//   drops until the output side drains.
`default_nettype none

module toy_byte_spn_cipher_ecb_cbc_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // input stream
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [7:0]                      s_axis_tdata,   // [7:0] data_in
  input  wire logic                            s_axis_tuser,   // [0] message_start
  // output stream
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic      [7:0]                      m_axis_tdata,   // [7:0] data_out
  // configuration
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [tbsc_pkg::AddrWidth-1:0]  paddr,
  input  wire logic [tbsc_pkg::DataWidth-1:0]  pwdata,
  output logic      [tbsc_pkg::DataWidth-1:0]  prdata,
  output logic                                 pready
);
  import tbsc_pkg::*;

  cfg_t       cfg;
  logic       in_valid_q;
  logic [7:0] in_data_q;
  logic       in_start_q;
  logic       out_valid_q;
  logic [7:0] out_data_q;
  logic [7:0] chain_q;
  logic [7:0] result;
  logic [7:0] chain_next;
  logic       out_free;
  logic       in_free;
  logic       advance;

  tbsc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tbsc_core u_core (
    .data_i       (in_data_q),
    .start_i      (in_start_q),
    .chain_i      (chain_q),
    .cfg_i        (cfg),
    .result_o     (result),
    .chain_next_o (chain_next)
  );

  // Handshake: each stage takes a beat when empty or when it drains
  assign out_free      = !out_valid_q || m_axis_tready;
  assign in_free       = !in_valid_q || out_free;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = in_free;

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      chain_q     <= 8'd0;
    end else begin
      if (in_free) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
      if (advance) begin
        chain_q <= chain_next;
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (in_free && s_axis_tvalid) begin
      in_data_q  <= s_axis_tdata;
      in_start_q <= s_axis_tuser;
    end
    if (advance) begin
      out_data_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire
